// File: rtl/core/fds_pkg.sv
`timescale 1ns / 1ps
// fds_pkg: sizes, codes and shared types of the dual free frame stack.
// No dependencies; imported by every other file of the block.
package fds_pkg;

  localparam int LOW_DEPTH  = 1024;
  localparam int HIGH_DEPTH = 1024;
  localparam int ADDR_BITS  = 52;

  localparam int LOW_AW  = (LOW_DEPTH > 1) ? $clog2(LOW_DEPTH) : 1;
  localparam int HIGH_AW = (HIGH_DEPTH > 1) ? $clog2(HIGH_DEPTH) : 1;
  localparam int LOW_W   = 32;   // low frames fit below 4 GiB
  localparam int CNT_W   = 11;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [CNT_W-1:0] LOW_LIM  = CNT_W'(LOW_DEPTH);
  localparam logic [CNT_W-1:0] HIGH_LIM = CNT_W'(HIGH_DEPTH);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(1024);

  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_POP      = 2'd1,
    ACT_POP_LOW  = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NO_PAE    = 3'd2,
    ST_LOW_FULL  = 3'd3,
    ST_HIGH_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_PAE      = 2'd0,
    REG_LOW_CAP  = 2'd1,
    REG_HIGH_CAP = 2'd2
  } reg_idx_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } fsm_t;

  typedef struct packed {
    logic             ext_addr_en;
    logic [CNT_W-1:0] low_capacity;
    logic [CNT_W-1:0] high_capacity;
  } cfg_t;

endpackage

// File: rtl/core/fds_req_if.sv
`timescale 1ns / 1ps
// fds_req_if: request channel (valid/ready plus action and frame address).
// Depends on fds_pkg.
interface fds_req_if import fds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           action;
  logic [ADDR_BITS-1:0] frame_addr;

  modport source (output valid, action, frame_addr, input ready);
  modport sink   (input valid, action, frame_addr, output ready);
endinterface

// File: rtl/core/fds_rsp_if.sv
`timescale 1ns / 1ps
// fds_rsp_if: result channel (valid/ready plus popped address, status, counts).
// Depends on fds_pkg.
interface fds_rsp_if import fds_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ADDR_BITS-1:0] popped_addr;
  status_t              status;
  logic [CNT_W-1:0]     low_free;
  logic [CNT_W-1:0]     high_free;

  modport source (output valid, popped_addr, status, low_free, high_free, input ready);
  modport sink   (input valid, popped_addr, status, low_free, high_free, output ready);
endinterface

// File: rtl/core/fds_ram.sv
`timescale 1ns / 1ps
// fds_ram: single-port-write, single-port-read synchronous RAM, registered read.
// Depends on fds_pkg (import only, sizes come in as parameters).
module fds_ram import fds_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/fds_apb_regs.sv
`timescale 1ns / 1ps
// fds_apb_regs: APB-style register file for PAE enable and both capacities.
// Depends on fds_pkg.
module fds_apb_regs import fds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ext_addr_en   <= 1'b0;
      cfg.low_capacity  <= CAP_RESET;
      cfg.high_capacity <= CAP_RESET;
    end else if (wr) begin
      case (idx)
        REG_PAE:      cfg.ext_addr_en   <= pwdata[0];
        REG_LOW_CAP:  cfg.low_capacity  <= pwdata[CNT_W-1:0];
        REG_HIGH_CAP: cfg.high_capacity <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_PAE:      prdata = PDATA_W'(cfg.ext_addr_en);
      REG_LOW_CAP:  prdata = PDATA_W'(cfg.low_capacity);
      REG_HIGH_CAP: prdata = PDATA_W'(cfg.high_capacity);
      default:      prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/dual_free_frame_stack.sv
`timescale 1ns / 1ps
// dual_free_frame_stack: two LIFO stacks of free page-frame addresses, top level.
// Depends on fds_pkg, fds_req_if, fds_rsp_if, fds_ram, fds_apb_regs.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------------
//  req     | in        | valid/ready      | action, frame_addr
//  rsp     | out       | valid/ready      | popped_addr, status, low_free, high_free
//  apb     | in        | psel/penable     | paddr, pwdata, prdata (pready tied high)
//
// A push, a refused request or an unused action is loaded into the output register
// at the accepting edge. A pop that takes an entry is first read into the registered
// output of the stack RAM, then loaded into the output register once it is free.
// Reset (rst, synchronous) empties both stacks by zeroing the counts; no RAM
// clear is needed. A new request is taken only while the output register is
// empty or being drained in the same cycle, so a stalled rsp holds req off.
module dual_free_frame_stack import fds_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  fds_req_if.sink            req,
  fds_rsp_if.source          rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;

  fds_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stack pointers: count = number of held entries, top lives at count-1.
  logic [CNT_W-1:0] low_count, low_count_next;
  logic [CNT_W-1:0] high_count, high_count_next;

  fsm_t state, state_next;

  // Output register.
  logic                 out_valid;
  logic [ADDR_BITS-1:0] out_addr;
  status_t              out_status;
  logic [CNT_W-1:0]     out_low, out_high;

  logic slot_free, accept, rd_load, imm_load;

  // RAM side.
  logic                 low_we, low_re, high_we, high_re;
  logic [LOW_AW-1:0]    low_waddr, low_raddr;
  logic [HIGH_AW-1:0]   high_waddr, high_raddr;
  logic [LOW_W-1:0]     low_rdata;
  logic [ADDR_BITS-1:0] high_rdata;

  // Decode of the incoming request.
  logic             is_high_frame, need_read, rd_high, rd_high_q;
  status_t          status_c;
  logic [CNT_W-1:0] low_lim, high_lim;

  assign slot_free = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Usable capacity is the smaller of register and depth.
  assign low_lim  = (cfg.low_capacity  < LOW_LIM)  ? cfg.low_capacity  : LOW_LIM;
  assign high_lim = (cfg.high_capacity < HIGH_LIM) ? cfg.high_capacity : HIGH_LIM;

  assign is_high_frame = |req.frame_addr[ADDR_BITS-1:32];

  always_comb begin
    status_c        = ST_OK;
    low_count_next  = low_count;
    high_count_next = high_count;
    low_we          = 1'b0;
    high_we         = 1'b0;
    need_read       = 1'b0;
    rd_high         = 1'b0;
    case (action_t'(req.action))
      ACT_PUSH: begin
        if (is_high_frame) begin
          if (!cfg.ext_addr_en) begin
            status_c = ST_NO_PAE;
          end else if (high_count >= high_lim) begin
            status_c = ST_HIGH_FULL;
          end else begin
            high_we         = 1'b1;
            high_count_next = high_count + CNT_W'(1);
          end
        end else if (low_count >= low_lim) begin
          status_c = ST_LOW_FULL;
        end else begin
          low_we         = 1'b1;
          low_count_next = low_count + CNT_W'(1);
        end
      end
      ACT_POP: begin
        if (high_count != '0) begin
          need_read       = 1'b1;
          rd_high         = 1'b1;
          high_count_next = high_count - CNT_W'(1);
        end else if (low_count != '0) begin
          need_read      = 1'b1;
          low_count_next = low_count - CNT_W'(1);
        end else begin
          status_c = ST_EMPTY;
        end
      end
      ACT_POP_LOW: begin
        if (low_count != '0) begin
          need_read      = 1'b1;
          low_count_next = low_count - CNT_W'(1);
        end else begin
          status_c = ST_EMPTY;
        end
      end
      default: ;  // unused code: ok, nothing changes
    endcase
  end

  // Push writes at the old count, pop reads at the new one.
  assign low_waddr  = low_count[LOW_AW-1:0];
  assign high_waddr = high_count[HIGH_AW-1:0];
  assign low_raddr  = low_count_next[LOW_AW-1:0];
  assign high_raddr = high_count_next[HIGH_AW-1:0];
  assign low_re     = accept && need_read && !rd_high;
  assign high_re    = accept && need_read && rd_high;

  fds_ram #(.DEPTH(LOW_DEPTH), .WIDTH(LOW_W)) u_low_ram (
    .clk   (clk),
    .we    (accept && low_we),
    .waddr (low_waddr),
    .wdata (req.frame_addr[LOW_W-1:0]),
    .re    (low_re),
    .raddr (low_raddr),
    .rdata (low_rdata)
  );

  fds_ram #(.DEPTH(HIGH_DEPTH), .WIDTH(ADDR_BITS)) u_high_ram (
    .clk   (clk),
    .we    (accept && high_we),
    .waddr (high_waddr),
    .wdata (req.frame_addr),
    .re    (high_re),
    .raddr (high_raddr),
    .rdata (high_rdata)
  );

  // FSM: next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && need_read) state_next = S_READ;
      S_READ: if (slot_free) state_next = S_IDLE;
    endcase
  end

  // FSM: outputs.
  always_comb begin
    req.ready = 1'b0;
    rd_load   = 1'b0;
    unique case (state)
      S_IDLE: req.ready = slot_free;
      S_READ: rd_load   = slot_free;
    endcase
  end

  assign imm_load = accept && !need_read;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      low_count  <= '0;
      high_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        low_count  <= low_count_next;
        high_count <= high_count_next;
      end
      if (imm_load || rd_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_high_q <= rd_high;
    end
    if (imm_load) begin
      out_addr   <= '0;
      out_status <= status_c;
      out_low    <= low_count_next;
      out_high   <= high_count_next;
    end else if (rd_load) begin
      out_addr   <= rd_high_q ? high_rdata : ADDR_BITS'(low_rdata);
      out_status <= ST_OK;
      out_low    <= low_count;
      out_high   <= high_count;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.popped_addr = out_addr;
  assign rsp.status      = out_status;
  assign rsp.low_free    = out_low;
  assign rsp.high_free   = out_high;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for dual_free_frame_stack (two free frame stacks).
// Depends on fds_pkg, fds_req_if, fds_rsp_if and the dual_free_frame_stack RTL.
module testbench;
  import fds_pkg::*;

  // The unused action code is not in the package enum.
  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [ADDR_BITS-1:0] FOUR_GIB = ADDR_BITS'(64'h1_0000_0000);
  localparam logic [ADDR_BITS-1:0] ADDR_ONES = '1;

  typedef struct {
    logic [1:0]           action;
    logic [ADDR_BITS-1:0] frame;
  } frame_req_t;

  typedef struct {
    logic [ADDR_BITS-1:0] popped;
    status_t              status;
    logic [CNT_W-1:0]     low_free;
    logic [CNT_W-1:0]     high_free;
  } stack_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  fds_req_if req_ch ();
  fds_rsp_if rsp_ch ();

  dual_free_frame_stack i_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #4 clk = ~clk;

  // Requests waiting to be driven, and results predicted but not yet seen.
  frame_req_t    req_backlog[$];
  stack_result_t frame_results_q[$];

  // Mirror of the block: both stacks, their counts and the register file.
  logic [LOW_W-1:0]     low_frames[LOW_DEPTH];
  logic [ADDR_BITS-1:0] high_frames[HIGH_DEPTH];
  logic [CNT_W-1:0]     low_cnt = '0;
  logic [CNT_W-1:0]     high_cnt = '0;
  logic                 pae_mirror = 1'b0;
  logic [CNT_W-1:0]     low_cap_mirror = CAP_RESET;
  logic [CNT_W-1:0]     high_cap_mirror = CAP_RESET;

  int         errors = 0;
  int         gap_left = 0;
  int         stall_left = 0;
  logic       req_taken = 1'b0;
  logic       no_idle = 1'b0;
  frame_req_t next_req;

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $time, what);
    errors++;
  endtask

  // Work out the result of one transaction and move the mirror state on.
  // Refused requests leave both stacks untouched.
  task automatic predict_stack_op(input logic [1:0] act, input logic [ADDR_BITS-1:0] fa,
                                  output stack_result_t r);
    logic [CNT_W-1:0] low_room;
    logic [CNT_W-1:0] high_room;
    low_room  = (low_cap_mirror < LOW_LIM) ? low_cap_mirror : LOW_LIM;
    high_room = (high_cap_mirror < HIGH_LIM) ? high_cap_mirror : HIGH_LIM;
    r.popped = '0;
    r.status = ST_OK;
    case (act)
      ACT_PUSH: begin
        if (fa >= FOUR_GIB) begin
          if (!pae_mirror) r.status = ST_NO_PAE;
          else if (high_cnt >= high_room) r.status = ST_HIGH_FULL;
          else begin
            high_frames[high_cnt[HIGH_AW-1:0]] = fa;
            high_cnt = high_cnt + 1'b1;
          end
        end else if (low_cnt >= low_room) begin
          r.status = ST_LOW_FULL;
        end else begin
          low_frames[low_cnt[LOW_AW-1:0]] = fa[LOW_W-1:0];
          low_cnt = low_cnt + 1'b1;
        end
      end
      ACT_POP: begin
        // high stack first, low stack as fallback
        if (high_cnt != 0) begin
          high_cnt = high_cnt - 1'b1;
          r.popped = high_frames[high_cnt[HIGH_AW-1:0]];
        end else if (low_cnt != 0) begin
          low_cnt = low_cnt - 1'b1;
          r.popped = ADDR_BITS'(low_frames[low_cnt[LOW_AW-1:0]]);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      ACT_POP_LOW: begin
        if (low_cnt != 0) begin
          low_cnt = low_cnt - 1'b1;
          r.popped = ADDR_BITS'(low_frames[low_cnt[LOW_AW-1:0]]);
        end else begin
          r.status = ST_EMPTY;
        end
      end
      default: ;  // unused code: no effect, status ok
    endcase
    r.low_free  = low_cnt;
    r.high_free = high_cnt;
  endtask

  // Driver: inputs move on the falling edge. A new transaction is presented
  // once the previous one was taken; random gaps follow some transactions.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (!req_ch.valid || req_taken) begin
        if (gap_left > 0) begin
          req_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_backlog.size() > 0) begin
          next_req = req_backlog.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.action     <= next_req.action;
          req_ch.frame_addr <= next_req.frame;
          if (!no_idle && $urandom_range(0, 3) == 0) gap_left <= $urandom_range(1, 8);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
      // result side: bursts of back-pressure
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 8);
      end
    end
  end

  // Monitor: sample both channels on the rising edge. The result is checked
  // before the request of the same edge is predicted, as it is always older.
  always @(posedge clk) begin
    stack_result_t want;
    stack_result_t got_pred;
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (frame_results_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = frame_results_q.pop_front();
          if (rsp_ch.popped_addr !== want.popped)
            report_mismatch($sformatf("popped_addr got %h want %h",
                                      rsp_ch.popped_addr, want.popped));
          if (rsp_ch.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", rsp_ch.status, want.status));
          if (rsp_ch.low_free !== want.low_free)
            report_mismatch($sformatf("low_free got %0d want %0d",
                                      rsp_ch.low_free, want.low_free));
          if (rsp_ch.high_free !== want.high_free)
            report_mismatch($sformatf("high_free got %0d want %0d",
                                      rsp_ch.high_free, want.high_free));
        end
      end
      req_taken <= req_ch.valid && req_ch.ready;
      if (req_ch.valid && req_ch.ready) begin
        predict_stack_op(req_ch.action, req_ch.frame_addr, got_pred);
        frame_results_q.push_back(got_pred);
      end
    end
  end

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, keep the mirror in step and read it back.
  task automatic write_register(input reg_idx_t idx, input logic [31:0] val);
    logic [31:0] rd;
    logic [31:0] mask;
    apb_access(1'b1, idx, val, rd);
    case (idx)
      REG_PAE: begin
        pae_mirror = val[0];
        mask = 32'h1;
      end
      REG_LOW_CAP: begin
        low_cap_mirror = val[CNT_W-1:0];
        mask = 32'h7FF;
      end
      default: begin
        high_cap_mirror = val[CNT_W-1:0];
        mask = 32'h7FF;
      end
    endcase
    apb_access(1'b0, idx, '0, rd);
    if ((rd & mask) !== (val & mask))
      report_mismatch($sformatf("register %0d read %h want %h", idx, rd & mask, val & mask));
  endtask

  // Block is idle once nothing is queued, driven or outstanding.
  task automatic wait_drained();
    do @(posedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || frame_results_q.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_stack_config(input logic pae, input logic [CNT_W-1:0] lcap,
                                  input logic [CNT_W-1:0] hcap);
    wait_drained();
    write_register(REG_PAE, 32'(pae));
    write_register(REG_LOW_CAP, 32'(lcap));
    write_register(REG_HIGH_CAP, 32'(hcap));
  endtask

  function automatic void add_req(input logic [1:0] act, input logic [ADDR_BITS-1:0] fa);
    frame_req_t it;
    it.action = act;
    it.frame  = fa;
    req_backlog.push_back(it);
  endfunction

  function automatic logic [ADDR_BITS-1:0] random_high_frame();
    logic [31:0] hi;
    hi = $urandom_range(1, (1 << (ADDR_BITS - 32)) - 1);
    return {hi[ADDR_BITS-33:0], 32'($urandom())};
  endfunction

  function automatic logic [ADDR_BITS-1:0] random_low_frame();
    return ADDR_BITS'($urandom());
  endfunction

  // Mostly pushes and pops in balance so that counts wander between empty and
  // full; frames mix low, high and the boundary values.
  function automatic frame_req_t random_request();
    frame_req_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 48) it.action = ACT_PUSH;
    else if (pick < 88) it.action = ACT_POP;
    else if (pick < 97) it.action = ACT_POP_LOW;
    else it.action = ACT_UNUSED;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: it.frame = '0;
          1: it.frame = ADDR_BITS'(32'hFFFF_FFFF);
          2: it.frame = FOUR_GIB;
          default: it.frame = ADDR_ONES;
        endcase
      end
      1, 2, 3, 4: it.frame = random_low_frame();
      default: it.frame = random_high_frame();
    endcase
    return it;
  endfunction

  function automatic logic [CNT_W-1:0] pick_capacity(input logic [CNT_W-1:0] floor_cap);
    case ($urandom_range(0, 5))
      0: return floor_cap;
      1: return CNT_W'(1);
      2, 3: return CNT_W'($urandom_range(2, 12));
      4: return CNT_W'($urandom_range(13, 64));
      default: return $urandom_range(0, 1) ? CAP_RESET : '1;
    endcase
  endfunction

  initial begin
    // every block input known from time zero
    req_ch.valid      = 1'b0;
    req_ch.action     = ACT_PUSH;
    req_ch.frame_addr = '0;
    rsp_ch.ready      = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, reset settings first: PAE off, full capacities.
    add_req(ACT_POP, '0);                      // pop with both stacks empty
    add_req(ACT_POP_LOW, ADDR_ONES);           // low-only pop, empty
    add_req(ACT_UNUSED, ADDR_ONES);            // unused code is ignored
    add_req(ACT_PUSH, FOUR_GIB);               // high frame refused, no PAE
    add_req(ACT_PUSH, ADDR_ONES);
    add_req(ACT_PUSH, '0);
    add_req(ACT_PUSH, ADDR_BITS'(32'hFFFF_FFFF));
    add_req(ACT_POP_LOW, '0);
    add_req(ACT_POP, ADDR_ONES);               // falls back to the low stack
    add_req(ACT_POP, '0);

    // Smallest low stack, zero-size high stack.
    set_stack_config(1'b1, 11'd1, 11'd0);
    add_req(ACT_PUSH, random_high_frame());    // high stack of size zero
    add_req(ACT_PUSH, random_low_frame());
    add_req(ACT_PUSH, random_low_frame());     // low stack full
    add_req(ACT_POP, '0);

    set_stack_config(1'b1, 11'd4, 11'd4);
    add_req(ACT_PUSH, FOUR_GIB);
    add_req(ACT_PUSH, ADDR_ONES);
    add_req(ACT_PUSH, ADDR_BITS'(5));
    add_req(ACT_PUSH, ADDR_BITS'(6));
    add_req(ACT_POP_LOW, '0);                  // low only, high left alone
    add_req(ACT_POP, '0);                      // high stack first

    // Capacities dropped to or under the counts held: pushes refused, pops drain.
    set_stack_config(1'b1, 11'd0, 11'd1);
    add_req(ACT_PUSH, random_low_frame());
    add_req(ACT_PUSH, random_high_frame());
    add_req(ACT_POP_LOW, '0);
    add_req(ACT_POP, '0);
    add_req(ACT_POP, '0);

    // Random phases over assorted settings.
    for (int p = 0; p < 8; p++) begin
      set_stack_config((p == 0) ? 1'b0 : ($urandom_range(0, 3) != 0),
                       pick_capacity(11'd1), pick_capacity(11'd0));
      repeat (65) req_backlog.push_back(random_request());
    end

    // Final stretch without any idling on either side.
    set_stack_config(1'b1, CNT_W'($urandom_range(2, 12)), CNT_W'($urandom_range(1, 12)));
    no_idle = 1'b1;
    repeat (60) req_backlog.push_back(random_request());

    wait_drained();
    repeat (8) @(posedge clk);
    if (frame_results_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", frame_results_q.size()));
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run of about 600 transactions.
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/fds_pkg.sv
rtl/core/fds_req_if.sv
rtl/core/fds_rsp_if.sv
rtl/core/fds_ram.sv
rtl/core/fds_apb_regs.sv
rtl/core/dual_free_frame_stack.sv
tb/testbench.sv
